// ===== sv/scfl_pkg.sv =====
// Shared types, constants and helpers for the size-class free-list allocator.
package scfl_pkg;

	localparam int GRANULE_BYTES     = 8;
	localparam int CLASS_COUNT       = 16;
	localparam int CHUNK_BYTES_LIMIT = 4096;
	localparam int CHUNK_NODE_CAP    = 64;
	localparam int POOL_BYTES        = 65536;

	localparam int POOL_GRANULES = POOL_BYTES / GRANULE_BYTES;
	localparam int GRAN_W        = $clog2(POOL_GRANULES);
	localparam int CLASS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int SHIFT_W       = $clog2(GRANULE_BYTES);
	localparam int CARVE_W       = $clog2(POOL_BYTES) + 1;
	localparam int NODES_W       = $clog2(CHUNK_NODE_CAP + 1);
	localparam int LINK_W        = GRAN_W + 1;

	localparam logic       ACT_ALLOC  = 1'b0;
	localparam logic       ACT_FREE   = 1'b1;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EXHAUST = 2'd1;
	localparam logic [1:0] ST_BADSIZE = 2'd2;

	typedef struct packed {
		logic        action;
		logic [7:0]  request_size;
		logic [15:0] block_address;
	} req_t;

	typedef struct packed {
		logic [15:0] result_address;
		logic [1:0]  status;
	} rsp_t;

	// Classified command handed from front to back.
	typedef struct packed {
		logic               bad;
		logic               is_free;
		logic [CLASS_W-1:0] cls;
		logic [GRAN_W:0]    gran;
	} cmd_t;

	// Largest node count up to the cap that fits the chunk limit, at least one.
	function automatic logic [NODES_W-1:0] chunk_nodes(input int c);
		int nb, n;
		nb = (c + 1) * GRANULE_BYTES;
		n = 1;
		for (int i = 1; i <= CHUNK_NODE_CAP; i++)
			if (i * nb <= CHUNK_BYTES_LIMIT) n = i;
		return NODES_W'(n);
	endfunction

	function automatic logic [CARVE_W-1:0] chunk_bytes(input int c);
		int n;
		n = int'(chunk_nodes(c));
		return CARVE_W'(n * (c + 1) * GRANULE_BYTES);
	endfunction

endpackage

// ===== sv/scfl_ram.sv =====
// Generic single-port-write, registered-read RAM.
module scfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/scfl_front.sv =====
// Front end: take commands, classify size and address, fill a two-entry queue.
module scfl_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  scfl_pkg::req_t       req,
	output logic                 busy,
	output logic                 q_valid,
	output scfl_pkg::cmd_t       q_cmd,
	input  logic                 q_pop
);

	scfl_pkg::cmd_t cmd_d;
	scfl_pkg::cmd_t fifo_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;
	logic [7:0] sz_m1;
	logic [7-scfl_pkg::SHIFT_W:0] cls_wide;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;

	always_comb begin
		sz_m1 = req.request_size - 8'd1;
		cls_wide = sz_m1[7:scfl_pkg::SHIFT_W];
		cmd_d.is_free = (req.action == scfl_pkg::ACT_FREE);
		cmd_d.bad = (req.request_size == 8'd0) ||
			(32'(cls_wide) >= 32'(scfl_pkg::CLASS_COUNT));
		cmd_d.cls = scfl_pkg::CLASS_W'(cls_wide);
		cmd_d.gran = (scfl_pkg::GRAN_W + 1)'(req.block_address >> scfl_pkg::SHIFT_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= cmd_d;
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = fifo_q[rd_q];

`ifndef SYNTH
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_valid) else $error("busy with empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue overflow");
`endif

endmodule

// ===== sv/scfl_back.sv =====
// Back end: class lists, bump carving, link memory and result strobe.
module scfl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  scfl_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           done,
	output scfl_pkg::rsp_t rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CARVE = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;

	localparam int GW = scfl_pkg::GRAN_W;
	localparam int CW = scfl_pkg::CARVE_W;

	logic [2:0] state_q;
	logic [GW-1:0] head_q [scfl_pkg::CLASS_COUNT];
	logic [scfl_pkg::CLASS_COUNT-1:0] hvalid_q;
	logic [CW-1:0] carve_q;
	scfl_pkg::cmd_t cmd_q;
	logic [scfl_pkg::NODES_W-1:0] idx_q, nodes_q;
	logic [GW:0] g_q;
	logic [GW-1:0] first_q;
	logic [CW-1:0] cbytes;
	logic [scfl_pkg::NODES_W-1:0] cnodes;
	logic [GW:0] ngran;
	logic we;
	logic [GW-1:0] waddr, raddr;
	logic [scfl_pkg::LINK_W-1:0] wdata, rdata;

	always_comb begin
		cbytes = '0;
		cnodes = '0;
		for (int c = 0; c < scfl_pkg::CLASS_COUNT; c++) begin
			if (scfl_pkg::CLASS_W'(c) == cmd_q.cls) begin
				cbytes = scfl_pkg::chunk_bytes(c);
				cnodes = scfl_pkg::chunk_nodes(c);
			end
		end
		ngran = (GW + 1)'(cmd_q.cls) + 1'b1;
	end

	scfl_ram #(.WIDTH(scfl_pkg::LINK_W), .DEPTH(scfl_pkg::POOL_GRANULES)) u_link (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

	assign raddr = head_q[cmd_q.cls];

	always_comb begin
		we = 1'b0;
		waddr = g_q[GW-1:0];
		wdata = '0;
		q_pop = 1'b0;
		// the fit-check cycle (no node count yet) writes nothing
		if (state_q == S_CARVE && nodes_q != '0 && !g_q[GW]) begin
			we = 1'b1;
			wdata = (idx_q + 1'b1 < nodes_q) ? {1'b1, GW'(g_q + ngran)} : '0;
		end else if (state_q == S_IDLE && q_valid && !q_cmd.bad && q_cmd.is_free
				&& !q_cmd.gran[GW]) begin
			we = 1'b1;
			waddr = q_cmd.gran[GW-1:0];
			wdata = {hvalid_q[q_cmd.cls], head_q[q_cmd.cls]};
		end
		if (state_q == S_IDLE && q_valid) q_pop = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hvalid_q <= '0;
			carve_q <= '0;
			done <= 1'b0;
			rsp <= '0;
			cmd_q <= '0;
			nodes_q <= '0;
			idx_q <= '0;
			g_q <= '0;
			first_q <= '0;
			for (int c = 0; c < scfl_pkg::CLASS_COUNT; c++) head_q[c] <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_cmd;
						rsp <= '{16'd0, q_cmd.bad ? scfl_pkg::ST_BADSIZE : scfl_pkg::ST_OK};
						if (q_cmd.bad) begin
							done <= 1'b1;
						end else if (q_cmd.is_free) begin
							if (!q_cmd.gran[GW]) begin
								head_q[q_cmd.cls] <= q_cmd.gran[GW-1:0];
								hvalid_q[q_cmd.cls] <= 1'b1;
							end
							done <= 1'b1;
						end else if (hvalid_q[q_cmd.cls]) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_CARVE;
						end
					end
				end
				S_CARVE: begin
					// first cycle: check fit and set up the walk
					if (nodes_q == '0) begin
						if (carve_q > CW'(scfl_pkg::POOL_BYTES) ||
							cbytes > CW'(scfl_pkg::POOL_BYTES) - carve_q) begin
							rsp.status <= scfl_pkg::ST_EXHAUST;
							done <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							nodes_q <= cnodes;
							idx_q <= '0;
							g_q <= (GW + 1)'(carve_q >> scfl_pkg::SHIFT_W);
							first_q <= GW'(carve_q >> scfl_pkg::SHIFT_W);
						end
					end else if (idx_q + 1'b1 >= nodes_q || g_q[GW]) begin
						carve_q <= carve_q + cbytes;
						head_q[cmd_q.cls] <= first_q;
						hvalid_q[cmd_q.cls] <= 1'b1;
						nodes_q <= '0;
						state_q <= S_READ;
					end else begin
						idx_q <= idx_q + 1'b1;
						g_q <= g_q + ngran;
					end
				end
				S_READ: state_q <= S_POP;
				S_POP: begin
					// link read was issued the cycle before
					head_q[cmd_q.cls] <= rdata[GW-1:0];
					hvalid_q[cmd_q.cls] <= rdata[GW];
					rsp.result_address <= 16'(32'(head_q[cmd_q.cls]) * scfl_pkg::GRANULE_BYTES);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE) else $error("pop outside idle");
	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> $past(state_q) == S_READ)
		else $error("pop without link read");
	a_done_ok_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != scfl_pkg::ST_OK |-> rsp.result_address == 16'd0)
		else $error("error result carries address");
`endif

endmodule

// ===== sv/size_class_free_list_allocator.sv =====
// Top level of the size-class free-list allocator.
//  channel | handshake           | word
//  command | start / busy        | req (action, request_size, block_address)
//  result  | done (one cycle)    | rsp (result_address, status)
// Free and bad size: result straight from the idle back end. Pop: link read, then pop.
// Refill: a fit check, then one node linked per step (up to the cap), then the pop.
// Pool exhausted: result on the failed fit check. A two-entry queue takes commands
// while the back end works. Reset clears class lists and the carve pointer; link RAM
// is not cleared. Results cannot be stalled.
module size_class_free_list_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  scfl_pkg::req_t req,
	output logic           done,
	output scfl_pkg::rsp_t rsp
);

	logic           q_valid, q_pop;
	scfl_pkg::cmd_t q_cmd;

	scfl_front u_front (.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

	scfl_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd),
		.q_pop(q_pop), .done(done), .rsp(rsp));

endmodule
